// ----- rtl/sat_pkg.sv -----
// Package for the shift array table: transaction structs, operation codes
// and size constants. No dependencies.
package sat_pkg;

  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;
  localparam int KIND_W    = 4;
  localparam int DEPTH_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SHL    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_SHR    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ROTL   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_ROTR   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_INSERT = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DELETE = 4'd7;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } sat_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [POS_W-1:0]         found_position;
    logic                     found;
    logic                     bad_position;
  } sat_out_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                     en;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } sat_cmd_t;

endpackage

// ----- rtl/sat_cell.sv -----
// One storage cell of the shift array row.
// Depends on sat_pkg; takes its neighbors' words and the broadcast command.
module sat_cell import sat_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sat_cmd_t                 cmd,
  input  logic signed [WORD_W-1:0] from_left,
  input  logic signed [WORD_W-1:0] from_right,
  output logic signed [WORD_W-1:0] word,
  output logic                     eq,
  output logic                     hit
);

  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] word_nxt;
  logic                     after;

  assign hit   = int'(cmd.position) == IDX + 1;
  assign after = int'(cmd.position) < IDX + 1;
  assign eq    = word_r == cmd.value;
  assign word  = word_r;

  always_comb begin
    word_nxt = word_r;
    if (cmd.en) begin
      unique case (cmd.kind)
        KIND_LOAD:   if (hit) word_nxt = cmd.value;
        KIND_SHL,
        KIND_ROTL:   word_nxt = from_right;
        KIND_SHR,
        KIND_ROTR:   word_nxt = from_left;
        KIND_INSERT: begin
          if (hit) begin
            word_nxt = cmd.value;
          end else if (after) begin
            word_nxt = from_left;
          end
        end
        KIND_DELETE: if (hit || after) word_nxt = from_right;
        default:     word_nxt = word_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

endmodule

// ----- rtl/shift_array_table_ops_top.sv -----
// Top level of the shift array table: a row of sat_cell instances, the
// position check, read/search result logic and the output register. Uses sat_pkg.
//
// Each transaction carries one operation and returns exactly one result
// transaction in the cycle after it is accepted. The whole row of cells updates
// from its neighbors in the accepting cycle and search compares every cell at
// once, so a new transaction is taken every cycle as long as the result
// register is empty or is being drained in that same cycle. The contents are
// all zero after reset.
module shift_array_table_ops_top import sat_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sat_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sat_out_t out_data
);

  logic signed [WORD_W-1:0] words [DEPTH];
  logic [DEPTH-1:0]         eq_vec;
  logic [DEPTH-1:0]         hit_vec;
  logic signed [WORD_W-1:0] left_end;
  logic signed [WORD_W-1:0] right_end;
  sat_cmd_t                 cmd;
  logic                     accept;
  logic                     needs_pos;
  logic                     bad;
  logic signed [WORD_W-1:0] rd_word;
  logic [POS_W-1:0]         match_pos;
  logic                     match;
  sat_out_t                 res;
  sat_out_t                 out_data_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign needs_pos = in_data.kind == KIND_LOAD || in_data.kind == KIND_READ ||
                     in_data.kind == KIND_INSERT || in_data.kind == KIND_DELETE;
  assign bad = needs_pos && (in_data.position == '0 || int'(in_data.position) > DEPTH);

  assign cmd.en       = accept && !bad;
  assign cmd.kind     = in_data.kind;
  assign cmd.position = in_data.position;
  assign cmd.value    = in_data.value;

  assign left_end  = (in_data.kind == KIND_ROTR) ? words[DEPTH-1] : '0;
  assign right_end = (in_data.kind == KIND_ROTL) ? words[0] : '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sat_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .from_left  ((g == 0) ? left_end : words[(g == 0) ? 0 : g-1]),
      .from_right ((g == DEPTH-1) ? right_end : words[(g == DEPTH-1) ? g : g+1]),
      .word       (words[g]),
      .eq         (eq_vec[g]),
      .hit        (hit_vec[g])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) rd_word = rd_word | words[i];
    end
  end

  // first match wins
  always_comb begin
    match_pos = '0;
    match     = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (eq_vec[i]) begin
        match_pos = POS_W'(i + 1);
        match     = 1'b1;
      end
    end
  end

  always_comb begin
    res = '0;
    if (bad) begin
      res.bad_position = 1'b1;
    end else begin
      unique case (in_data.kind)
        KIND_READ,
        KIND_DELETE: res.data_out = rd_word;
        KIND_SEARCH: begin
          res.found_position = match_pos;
          res.found          = match;
        end
        default: res = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/sat_checker.sv -----
// Port-level checks for shift_array_table_ops_top, bound to the top level.
// Depends on sat_pkg.
module sat_checker import sat_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input sat_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input sat_out_t out_data
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result path free");

  a_bad_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_position |->
      out_data.data_out == '0 && !out_data.found && out_data.found_position == '0)
    else $error("bad position result carries data");

  a_found_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.data_out == '0 && !out_data.bad_position)
    else $error("search result mixed with other fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind shift_array_table_ops_top sat_checker u_sat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
